### design/assert_macros.svh
// Assertion shorthands used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds this cycle -> consequent holds this cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Antecedent holds this cycle -> consequent holds next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/fmsyn_pkg.sv
// Shared types, constants and small decode functions for the FM write sequencer.
package fmsyn_pkg;

  typedef enum logic [2:0] {
    OP_KEY_ON  = 3'd0,
    OP_KEY_OFF = 3'd1,
    OP_VOLUME  = 3'd2,
    OP_VOICE   = 3'd3,
    OP_LOAD    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_VOICE,
    SQ_FREQ,
    SQ_KEYHI
  } seq_state_t;

  typedef enum logic [1:0] {
    FQ_IDLE,
    FQ_CHK,
    FQ_FIX,
    FQ_NORM
  } frq_state_t;

  typedef struct packed {
    logic       done;
    logic [9:0] fnum;
    logic [2:0] blk;
  } frq_res_t;

  localparam int unsigned PATCH_BYTES = 11;
  localparam logic [3:0]  VOICE_LAST  = 4'd10;

  localparam logic [7:0] REG_VOLUME  = 8'h40;
  localparam logic [7:0] REG_FNUM_LO = 8'hA0;
  localparam logic [7:0] REG_KEY     = 8'hB0;
  localparam logic [7:0] REG_FB      = 8'hC0;
  localparam logic [7:0] KEY_ON_BIT  = 8'h20;

  // Hz -> F-number scale is 65536/3125, done as a reciprocal multiply
  // (2^33/3125, floored) with one correction step.
  localparam logic [21:0] RECIP       = 22'd2748779;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [11:0] DIVISOR     = 12'd3125;
  localparam logic [20:0] FNUM_MAX    = 21'h0003FF;

  function automatic logic chip_of(input logic [4:0] v);
    return (v >= 5'd11) && (v < 5'd22);
  endfunction

  function automatic logic [3:0] chan_of(input logic [4:0] v);
    logic [4:0] r;
    begin
      if (v < 5'd11)      r = v;
      else if (v < 5'd22) r = v - 5'd11;
      else                r = v - 5'd22;
      return r[3:0];
    end
  endfunction

  // Operator cell offset of a channel: ch % 3 + 8 * (ch / 3).
  function automatic logic [4:0] cell_off(input logic [3:0] ch);
    logic [4:0] c;
    begin
      c = {1'b0, ch};
      if (ch < 4'd3)      return c;
      else if (ch < 4'd6) return c + 5'd5;
      else if (ch < 4'd9) return c + 5'd10;
      else                return c + 5'd15;
    end
  endfunction

  // Patch byte read at each step of a voice load (feedback byte goes last).
  function automatic logic [3:0] voice_src(input logic [3:0] k);
    logic [3:0] s;
    begin
      case (k)
        4'd8:    s = 4'd9;
        4'd9:    s = 4'd10;
        4'd10:   s = 4'd8;
        default: s = k;
      endcase
      return s;
    end
  endfunction

  // Register address written at each step of a voice load.
  function automatic logic [7:0] voice_addr(input logic [3:0] k, input logic [3:0] ch,
                                            input logic [4:0] off);
    logic [7:0] base;
    logic [7:0] opr_off;
    begin
      opr_off = {3'b000, off} + (k[0] ? 8'd3 : 8'd0);
      case (k[3:1])
        3'd0:    base = 8'h20;
        3'd1:    base = 8'h40;
        3'd2:    base = 8'h60;
        3'd3:    base = 8'h80;
        3'd4:    base = 8'hE0;
        default: base = 8'h00;
      endcase
      if (k >= VOICE_LAST) return REG_FB + {4'b0000, ch};
      else                 return base + opr_off;
    end
  endfunction

endpackage

### design/fmsyn_patch_mem.sv
// Patch byte store: one write port, one read port, registered read data.
module fmsyn_patch_mem #(
  parameter int unsigned DEPTH = 352,
  parameter int unsigned AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/fmsyn_freq.sv
// Hz to F-number/block converter: reciprocal multiply, correction, serial halving.
module fmsyn_freq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         value,
  output fmsyn_pkg::frq_res_t res
);
  import fmsyn_pkg::*;

  frq_state_t  state_r, state_nxt;
  logic [15:0] val_r;
  logic [20:0] q_r;
  logic [32:0] chk_r;
  logic [20:0] f_r, f_nxt;
  logic [3:0]  blk_r, blk_nxt;
  logic [37:0] prod;
  logic [32:0] rem;
  logic        fits;

  assign prod = {22'd0, value} * {16'd0, RECIP};
  assign rem  = {1'b0, val_r, 16'd0} - chk_r;
  assign fits = f_r <= FNUM_MAX;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FQ_IDLE: if (start) state_nxt = FQ_CHK;
      FQ_CHK:  state_nxt = FQ_FIX;
      FQ_FIX:  state_nxt = FQ_NORM;
      FQ_NORM: if (fits) state_nxt = FQ_IDLE;
      default: state_nxt = FQ_IDLE;
    endcase
  end

  always_comb begin
    f_nxt    = f_r;
    blk_nxt  = blk_r;
    res.done = 1'b0;
    res.fnum = f_r[9:0];
    res.blk  = blk_r[2:0];
    unique case (state_r)
      FQ_FIX: begin
        // estimate is exact or one low
        f_nxt   = q_r + ((rem >= {21'd0, DIVISOR}) ? 21'd1 : 21'd0);
        blk_nxt = '0;
      end
      FQ_NORM: begin
        if (fits) begin
          res.done = 1'b1;
        end else begin
          f_nxt   = {1'b0, f_r[20:1]};
          blk_nxt = blk_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FQ_IDLE && start) begin
      val_r <= value;
      q_r   <= prod[RECIP_SHIFT +: 21];
    end
    if (state_r == FQ_CHK) begin
      chk_r <= {12'd0, q_r} * {21'd0, DIVISOR};
    end
    f_r   <= f_nxt;
    blk_r <= blk_nxt;
  end

endmodule

### design/fmsyn_seq.sv
// Command sequencer: decodes requests, walks voice loads, formats register writes.
module fmsyn_seq #(
  parameter int unsigned AW = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          op,
  input  logic [4:0]          voice,
  input  logic [3:0]          byte_slot,
  input  logic [15:0]         value,
  input  logic                enable,
  input  logic [AW-1:0]       patch_base,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [7:0]          mem_rdata,
  output logic                frq_start,
  input  fmsyn_pkg::frq_res_t frq_res,
  output logic                out_strobe,
  output logic                out_chip_sel,
  output logic [7:0]          out_reg_addr,
  output logic [7:0]          out_reg_data,
  output logic                out_last
);
  import fmsyn_pkg::*;

  seq_state_t    state_r, state_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [3:0]    ch_r, ch_nxt;
  logic [4:0]    off_r, off_nxt;
  logic          chip_r, chip_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic          ostb_r, ostb_nxt;
  logic          ochip_r, ochip_nxt;
  logic [7:0]    oaddr_r, oaddr_nxt;
  logic [7:0]    odata_r, odata_nxt;
  logic          olast_r, olast_nxt;
  logic          omem_r, omem_nxt;

  logic       accept;
  op_t        cmd;
  logic [3:0] v_ch;
  logic       v_chip;

  assign accept = start && (state_r == SQ_IDLE);
  assign busy   = state_r != SQ_IDLE;
  assign cmd    = op_t'(op);
  assign v_ch   = chan_of(voice);
  assign v_chip = chip_of(voice);

  assign mem_waddr = patch_base + AW'(byte_slot);
  assign mem_wdata = value[7:0];
  assign mem_raddr = base_r + AW'(voice_src(k_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          case (cmd)
            OP_KEY_ON: if (enable) state_nxt = SQ_FREQ;
            OP_VOICE:  state_nxt = SQ_VOICE;
            default:   state_nxt = SQ_IDLE;
          endcase
        end
      end
      SQ_VOICE: if (k_r == VOICE_LAST) state_nxt = SQ_IDLE;
      SQ_FREQ:  if (frq_res.done) state_nxt = SQ_KEYHI;
      SQ_KEYHI: state_nxt = SQ_IDLE;
      default:  state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    k_nxt     = k_r;
    ch_nxt    = ch_r;
    off_nxt   = off_r;
    chip_nxt  = chip_r;
    base_nxt  = base_r;
    hi_nxt    = hi_r;
    ostb_nxt  = 1'b0;
    ochip_nxt = ochip_r;
    oaddr_nxt = oaddr_r;
    odata_nxt = odata_r;
    olast_nxt = 1'b0;
    omem_nxt  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    frq_start = 1'b0;
    unique case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          ch_nxt   = v_ch;
          off_nxt  = cell_off(v_ch);
          chip_nxt = v_chip;
          base_nxt = patch_base;
          k_nxt    = '0;
          case (cmd)
            OP_KEY_ON: frq_start = enable;
            OP_KEY_OFF: begin
              if (enable) begin
                ostb_nxt  = 1'b1;
                ochip_nxt = v_chip;
                oaddr_nxt = REG_KEY + {4'b0000, v_ch};
                odata_nxt = 8'h00;
                olast_nxt = 1'b1;
              end
            end
            OP_VOLUME: begin
              ostb_nxt  = 1'b1;
              ochip_nxt = v_chip;
              oaddr_nxt = REG_VOLUME + {4'b0000, v_ch};
              odata_nxt = value[7:0];
              olast_nxt = 1'b1;
            end
            OP_LOAD: mem_we = byte_slot < 4'(PATCH_BYTES);
            default: ;
          endcase
        end
      end
      SQ_VOICE: begin
        // read issued now; data lines up with the write next cycle
        mem_re    = 1'b1;
        ostb_nxt  = 1'b1;
        ochip_nxt = chip_r;
        oaddr_nxt = voice_addr(k_r, ch_r, off_r);
        omem_nxt  = 1'b1;
        olast_nxt = k_r == VOICE_LAST;
        k_nxt     = k_r + 4'd1;
      end
      SQ_FREQ: begin
        if (frq_res.done) begin
          ostb_nxt  = 1'b1;
          ochip_nxt = chip_r;
          oaddr_nxt = REG_FNUM_LO + {4'b0000, ch_r};
          odata_nxt = frq_res.fnum[7:0];
          hi_nxt    = KEY_ON_BIT | {3'b000, frq_res.blk, frq_res.fnum[9:8]};
        end
      end
      SQ_KEYHI: begin
        ostb_nxt  = 1'b1;
        ochip_nxt = chip_r;
        oaddr_nxt = REG_KEY + {4'b0000, ch_r};
        odata_nxt = hi_r;
        olast_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      ostb_r  <= 1'b0;
      olast_r <= 1'b0;
      omem_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ostb_r  <= ostb_nxt;
      olast_r <= olast_nxt;
      omem_r  <= omem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    ch_r    <= ch_nxt;
    off_r   <= off_nxt;
    chip_r  <= chip_nxt;
    base_r  <= base_nxt;
    hi_r    <= hi_nxt;
    ochip_r <= ochip_nxt;
    oaddr_r <= oaddr_nxt;
    odata_r <= odata_nxt;
  end

  assign out_strobe   = ostb_r;
  assign out_chip_sel = ochip_r;
  assign out_reg_addr = oaddr_r;
  assign out_reg_data = omem_r ? mem_rdata : odata_r;
  assign out_last     = olast_r;

endmodule

### design/fm_synth_register_write_sequencer.sv
// Top level of the FM synthesizer register write sequencer.
//
//   channel   direction  handshake               payload
//   request   in         start / busy            in_op, in_voice, in_patch,
//                                                in_byte_slot, in_value
//   result    out        out_strobe (no stall)   out_chip_sel, out_reg_addr,
//                                                out_reg_data, out_last
//   config    in/out     psel/penable/pready     paddr, pwdata, prdata
//
// A request is taken when start is high and busy is low.
// Volume, key off, load and ignored ops leave busy low.
// Set voice holds busy while it reads the patch, one patch store read per cycle;
//   each write follows its read in the next cycle; the last write shows as busy drops.
// Key on holds busy through the converter: multiply, correct, then one halving
//   per cycle until the F-number fits 10 bits, then two writes.
// Reset (rst_n low, synchronous) clears control state and the enable bit;
//   the patch store is not cleared and must be loaded before use.
module fm_synth_register_write_sequencer #(
  parameter int unsigned NUM_PATCHES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [4:0]  in_voice,
  input  logic [4:0]  in_patch,
  input  logic [3:0]  in_byte_slot,
  input  logic [15:0] in_value,
  // result channel
  output logic        out_strobe,
  output logic        out_chip_sel,
  output logic [7:0]  out_reg_addr,
  output logic [7:0]  out_reg_data,
  output logic        out_last,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmsyn_pkg::*;

  localparam int unsigned DEPTH = NUM_PATCHES * PATCH_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  // enable register, decoded at addresses 0 to 3 (paddr[2] low)
  logic enable_r, enable_nxt;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  always_comb begin
    enable_nxt = enable_r;
    if (cfg_wr) enable_nxt = pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {31'd0, enable_r} : 32'd0;

  // Slot base address per patch number, wrapped modulo the slot count;
  // every entry is a constant, so this is a small lookup on in_patch.
  logic [AW-1:0] slot_base [32];
  for (genvar g = 0; g < 32; g++) begin : g_slot
    assign slot_base[g] = AW'((g % NUM_PATCHES) * PATCH_BYTES);
  end

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          frq_start;
  frq_res_t      frq_res;

  fmsyn_patch_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fmsyn_freq u_freq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (frq_start),
    .value (in_value),
    .res   (frq_res)
  );

  fmsyn_seq #(
    .AW (AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (in_op),
    .voice        (in_voice),
    .byte_slot    (in_byte_slot),
    .value        (in_value),
    .enable       (enable_r),
    .patch_base   (slot_base[in_patch]),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .frq_start    (frq_start),
    .frq_res      (frq_res),
    .out_strobe   (out_strobe),
    .out_chip_sel (out_chip_sel),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_last     (out_last)
  );

  `include "assert_macros.svh"

  // converter finishes only while a key-on request holds the sequencer
  `ASSERT_IMPLIES(a_frq_done_busy, frq_res.done, busy)
  // set voice request must hold busy for its read walk
  `ASSERT_NEXT(a_voice_busy, start && !busy && in_op == OP_VOICE, busy)
  // voice reads stay inside the patch store
  `ASSERT_IMPLIES(a_rd_range, mem_re, mem_raddr < AW'(DEPTH))
  // end-of-command marker never appears without a write
  `ASSERT_IMPLIES(a_last_strobe, out_last, out_strobe)

endmodule

### sim/fm_synth_register_write_sequencer_tb.sv
// Testbench for the FM synthesizer register write sequencer: directed and random requests.
module fm_synth_register_write_sequencer_tb;
  import fmsyn_pkg::*;

  // Ops above OP_LOAD are undefined and must be dropped by the block.
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;
  localparam logic [2:0] ADDR_ENABLE = 3'd0;

  // Operator register bases for a voice load, and the patch byte each takes
  // (the second operator reads the following byte). Feedback goes last.
  localparam logic [7:0] OPER_BASE [5] = '{8'h20, 8'h40, 8'h60, 8'h80, 8'hE0};
  localparam int         OPER_SRC  [5] = '{0, 2, 4, 6, 9};
  localparam int         FB_SRC        = 8;

  localparam int IDLE_TAIL = 24;   // covers the longest key on conversion
  localparam int WDOG_MAX  = 2000; // cycles with no request, write or config access

  typedef struct packed {
    logic       chip_sel;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } reg_write_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_op;
  logic [4:0]  in_voice;
  logic [4:0]  in_patch;
  logic [3:0]  in_byte_slot;
  logic [15:0] in_value;
  logic        out_strobe;
  logic        out_chip_sel;
  logic [7:0]  out_reg_addr;
  logic [7:0]  out_reg_data;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fm_synth_register_write_sequencer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_voice     (in_voice),
    .in_patch     (in_patch),
    .in_byte_slot (in_byte_slot),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_chip_sel (out_chip_sel),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow state: enable bit, patch image and which bytes have been loaded.
  // Voice loads are only issued on slots whose 11 bytes are all known.
  logic        enable_shadow;
  logic [7:0]  patch_img   [32][PATCH_BYTES];
  logic [10:0] byte_loaded [32];

  reg_write_t pending_writes[$];

  int errors;
  int writes_checked;
  int requests_sent;
  int effective_requests;  // requests that write or load something
  int voice_loads;
  int key_ons;
  int sender_idle_pct;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: turns one accepted request into the register writes it causes.
  // Returns 1 when the request has any effect (writes or a real patch load).
  // ---------------------------------------------------------------------------
  function automatic void push_write(input logic chip, input logic [7:0] addr,
                                     input logic [7:0] data, input logic fin);
    reg_write_t w;
    w.chip_sel = chip;
    w.reg_addr = addr;
    w.reg_data = data;
    w.last     = fin;
    pending_writes.push_back(w);
  endfunction

  function automatic bit predict_command(input logic [2:0] op, input logic [4:0] voice,
                                         input logic [4:0] patch, input logic [3:0] bslot,
                                         input logic [15:0] value);
    logic            chip;
    logic [3:0]      ch;
    logic [7:0]      off;
    longint unsigned fnum;
    int unsigned     blk;
    logic [2:0]      blk3;
    bit              acted;
    chip  = 1'((voice / 5'd11) & 5'd1);   // voices 22..31 wrap back to chip 0
    ch    = 4'(voice % 5'd11);
    off   = 8'(ch % 4'd3) + 8'((ch / 4'd3) * 8);
    acted = 1'b0;
    case (op)
      OP_KEY_ON: begin
        if (enable_shadow) begin
          // Hz * 65536/3125, halved until it fits 10 bits; block count wraps
          fnum = longint'(value) * 64'd65536 / 64'd3125;
          blk  = 0;
          while (fnum > 64'h3FF) begin
            fnum = fnum >> 1;
            blk++;
          end
          blk3 = blk[2:0];
          push_write(chip, REG_FNUM_LO + 8'(ch), fnum[7:0], 1'b0);
          push_write(chip, REG_KEY + 8'(ch), KEY_ON_BIT | {3'b000, blk3, fnum[9:8]}, 1'b1);
          key_ons++;
          acted = 1'b1;
        end
      end
      OP_KEY_OFF: begin
        if (enable_shadow) begin
          push_write(chip, REG_KEY + 8'(ch), 8'h00, 1'b1);
          acted = 1'b1;
        end
      end
      OP_VOLUME: begin
        push_write(chip, REG_VOLUME + 8'(ch), value[7:0], 1'b1);
        acted = 1'b1;
      end
      OP_VOICE: begin
        for (int g = 0; g < 5; g++) begin
          push_write(chip, OPER_BASE[g] + off, patch_img[patch][OPER_SRC[g]], 1'b0);
          push_write(chip, OPER_BASE[g] + off + 8'd3, patch_img[patch][OPER_SRC[g] + 1],
                     1'b0);
        end
        push_write(chip, REG_FB + 8'(ch), patch_img[patch][FB_SRC], 1'b1);
        voice_loads++;
        acted = 1'b1;
      end
      OP_LOAD: begin
        // byte slots 11..15 are dropped
        if (bslot < 4'(PATCH_BYTES)) begin
          patch_img[patch][bslot] = value[7:0];
          byte_loaded[patch][bslot] = 1'b1;
          acted = 1'b1;
        end
      end
      default: ;
    endcase
    return acted;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. start stays high between back-to-back requests; it only
  // drops for an idle gap or a drain.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] op, input logic [4:0] voice,
                              input logic [4:0] patch, input logic [3:0] bslot,
                              input logic [15:0] value);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_voice     <= voice;
    in_patch     <= patch;
    in_byte_slot <= bslot;
    in_value     <= value;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (predict_command(op, voice, patch, bslot, value)) effective_requests++;
  endtask

  // Sender holds off until every predicted write has shown up.
  task automatic drain_writes();
    @(negedge clk);
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  // Config write: drain first, then let any request with no writes finish.
  task automatic write_enable(input logic en);
    drain_writes();
    repeat (IDLE_TAIL) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENABLE;
    pwdata  <= {31'd0, en};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    enable_shadow = en;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic bit slot_full(input logic [4:0] s);
    return &byte_loaded[s];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Key on/off must be dropped while disabled; volume still goes through.
  task automatic test_disabled_keys();
    write_enable(1'b0);
    send_request(OP_KEY_ON, 5'd3, 5'd0, 4'd0, 16'd440);
    send_request(OP_KEY_OFF, 5'd3, 5'd0, 4'd0, 16'd0);
    send_request(OP_VOLUME, 5'd11, 5'd0, 4'd0, 16'hFF00);
  endtask

  // Fill slot 31, poke the dropped byte slots, then load voices across both
  // chips, channel 10 and the wrapped voice numbers.
  task automatic test_patch_load_and_voice();
    logic [15:0] v;
    for (int b = 0; b < PATCH_BYTES; b++) begin
      if (b == 0)      v = 16'h00FF;
      else if (b == 1) v = 16'hFF00;
      else             v = 16'($urandom);
      send_request(OP_LOAD, 5'd0, 5'd31, 4'(b), v);
    end
    send_request(OP_LOAD, 5'd0, 5'd31, 4'd11, 16'hA5A5);
    send_request(OP_LOAD, 5'd0, 5'd31, 4'd15, 16'h5A5A);
    send_request(OP_VOICE, 5'd0, 5'd31, 4'd0, 16'd0);
    send_request(OP_VOICE, 5'd21, 5'd31, 4'd0, 16'd0);
    send_request(OP_VOICE, 5'd31, 5'd31, 4'd0, 16'd0);
  endtask

  // Frequency extremes: zero, both sides of the first halving, and the top
  // value where the block count wraps past 7; then key off, volume and a reserved op.
  task automatic test_key_and_volume();
    send_request(OP_KEY_ON, 5'd0, 5'd0, 4'd0, 16'd0);
    send_request(OP_KEY_ON, 5'd10, 5'd0, 4'd0, 16'd48);
    send_request(OP_KEY_ON, 5'd21, 5'd0, 4'd0, 16'd49);
    send_request(OP_KEY_ON, 5'd31, 5'd0, 4'd0, 16'hFFFF);
    send_request(OP_KEY_OFF, 5'd10, 5'd0, 4'd0, 16'hFFFF);
    send_request(OP_VOLUME, 5'd21, 5'd0, 4'd0, 16'h00FF);
    send_request(OP_RSVD_HI, 5'd5, 5'd5, 4'd5, 16'h1234);
  endtask

  // Mostly well-formed patch/voice/note sequences, plus loose commands.
  task automatic random_command();
    int          pick;
    logic [4:0]  slot;
    logic [4:0]  voice;
    logic [15:0] freq;
    pick  = $urandom_range(99);
    slot  = 5'($urandom);
    voice = 5'($urandom);
    freq  = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(2000));
    if (pick < 25) begin
      for (int b = 0; b < PATCH_BYTES; b++) begin
        if ($urandom_range(7) == 0)
          send_request(OP_LOAD, 5'($urandom), slot, 4'($urandom_range(15, PATCH_BYTES)),
                       16'($urandom));
        send_request(OP_LOAD, 5'($urandom), slot, 4'(b), 16'($urandom));
      end
      send_request(OP_VOICE, voice, slot, 4'($urandom), 16'($urandom));
      if ($urandom_range(1)) begin
        send_request(OP_KEY_ON, voice, 5'($urandom), 4'($urandom), freq);
        send_request(OP_KEY_OFF, voice, 5'($urandom), 4'($urandom), 16'($urandom));
      end
    end else if (pick < 40) begin
      // find a fully loaded slot; fall back to a volume change
      for (int i = 0; i < 32 && !slot_full(slot); i++) slot = slot + 5'd1;
      if (slot_full(slot))
        send_request(OP_VOICE, voice, slot, 4'($urandom), 16'($urandom));
      else
        send_request(OP_VOLUME, voice, slot, 4'($urandom), 16'($urandom));
    end else if (pick < 60) begin
      send_request(OP_KEY_ON, voice, slot, 4'($urandom), freq);
    end else if (pick < 70) begin
      send_request(OP_KEY_OFF, voice, slot, 4'($urandom), 16'($urandom));
    end else if (pick < 85) begin
      send_request(OP_VOLUME, voice, slot, 4'($urandom), 16'($urandom));
    end else if (pick < 95) begin
      send_request(OP_LOAD, voice, slot, 4'($urandom), 16'($urandom));
    end else begin
      send_request(3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO)), voice, slot,
                   4'($urandom), 16'($urandom));
    end
  endtask

  // Run until n more effective requests went out, with a drain halfway.
  task automatic test_random(input int idle_pct, input int n);
    int goal;
    int half;
    sender_idle_pct = idle_pct;
    goal = effective_requests + n;
    half = effective_requests + n / 2;
    while (effective_requests < half) random_command();
    drain_writes();
    while (effective_requests < goal) random_command();
  endtask

  // ---------------------------------------------------------------------------
  // Write checker: every strobe must match the oldest predicted write.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : write_check
    reg_write_t want;
    if (rst_n && out_strobe) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: chip %0d addr %02h data %02h last %0d",
               out_chip_sel, out_reg_addr, out_reg_data, out_last);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        if (out_chip_sel !== want.chip_sel) begin
          $error("chip_sel: expected %0d, got %0d", want.chip_sel, out_chip_sel);
          errors++;
        end
        if (out_reg_addr !== want.reg_addr) begin
          $error("reg_addr: expected %02h, got %02h", want.reg_addr, out_reg_addr);
          errors++;
        end
        if (out_reg_data !== want.reg_data) begin
          $error("reg_data: expected %02h, got %02h", want.reg_data, out_reg_data);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
        writes_checked++;
      end
    end
  end

  // Watchdog: any request, write or config access counts as progress.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WDOG_MAX) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe || psel) stalled = 0;
      else stalled++;
    end
    $display("timeout: no progress for %0d cycles", WDOG_MAX);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = OP_KEY_ON;
    in_voice     = '0;
    in_patch     = '0;
    in_byte_slot = '0;
    in_value     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = ADDR_ENABLE;
    pwdata       = '0;
    enable_shadow   = 1'b0;
    errors          = 0;
    writes_checked  = 0;
    requests_sent   = 0;
    effective_requests = 0;
    voice_loads     = 0;
    key_ons         = 0;
    sender_idle_pct = 8;
    for (int s = 0; s < 32; s++) begin
      byte_loaded[s] = '0;
      for (int b = 0; b < PATCH_BYTES; b++) patch_img[s][b] = 8'h00;
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_disabled_keys();
    write_enable(1'b1);
    test_patch_load_and_voice();
    test_key_and_volume();

    // sender idles now and then; enabled
    test_random(8, 40);
    // sender idles half the time; keys dropped
    write_enable(1'b0);
    test_random(50, 40);
    // back to back; enabled again
    write_enable(1'b1);
    test_random(0, 40);

    drain_writes();
    repeat (IDLE_TAIL) @(posedge clk);

    $display("covered %0d requests (%0d voice loads, %0d key ons), %0d writes checked",
             requests_sent, voice_loads, key_ons, writes_checked);
    $display("enable toggled off/on, idle mix 8%%/50%%/0%%, mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/fmsyn_pkg.sv
design/fmsyn_patch_mem.sv
design/fmsyn_freq.sv
design/fmsyn_seq.sv
design/fm_synth_register_write_sequencer.sv
sim/fm_synth_register_write_sequencer_tb.sv
